// ===== rtl/text_console_writer_unit_defines.svh =====
// Assertion macros for the text console writer.
// The first form checks only outside reset; the second form also checks
// while reset is asserted.
`ifndef TEXT_CONSOLE_WRITER_UNIT_DEFINES_SVH
`define TEXT_CONSOLE_WRITER_UNIT_DEFINES_SVH

`ifndef SYNTH
`define TCW_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("text console writer assertion failed");
`define TCW_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("text console writer assertion failed");
`else
`define TCW_ASSERT(name, clk, rst_n, prop)
`define TCW_ASSERT_ALWAYS(name, clk, prop)
`endif

`endif

// ===== rtl/tcw_pkg.sv =====
`timescale 1ns / 1ps
package tcw_pkg;

  localparam int Columns   = 80;
  localparam int Rows      = 25;
  localparam int CellCount = Rows * Columns;
  localparam int CopyLen   = CellCount - Columns;
  localparam int AddrW     = $clog2(CellCount);
  localparam int ReadAddrW = 11;
  localparam int RowW      = 5;
  localparam int ColW      = 7;
  localparam int CharW     = 8;
  localparam int CellW     = 16;

  localparam logic [CharW-1:0] NewlineCode = 8'd10;
  localparam logic [CharW-1:0] SpaceCode   = 8'd32;
  localparam logic [CharW-1:0] AttrReset   = 8'd15;

  typedef logic [AddrW-1:0] addr_t;
  typedef logic [CellW-1:0] cell_t;
  typedef logic [RowW-1:0]  row_t;
  typedef logic [ColW-1:0]  col_t;

  // One write port and one read port of the screen memory.
  typedef struct packed {
    logic  we;
    addr_t waddr;
    cell_t wdata;
    logic  re;
    addr_t raddr;
  } ram_req_t;

  typedef struct packed {
    cell_t data;
    row_t  row;
    col_t  col;
  } result_t;

endpackage

// ===== rtl/tcw_screen_ram.sv =====
`timescale 1ns / 1ps
module tcw_screen_ram (
  input  logic              clk_i,
  input  tcw_pkg::ram_req_t req_i,
  output tcw_pkg::cell_t    rd_data_o
);

  tcw_pkg::cell_t mem_q [tcw_pkg::CellCount];
  tcw_pkg::cell_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rd_data_q <= mem_q[req_i.raddr];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== rtl/tcw_ctrl.sv =====
`timescale 1ns / 1ps
module tcw_ctrl (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            op_i,
  input  logic [tcw_pkg::CharW-1:0]       char_code_i,
  input  logic [tcw_pkg::ReadAddrW-1:0]   read_address_i,
  input  logic [tcw_pkg::CharW-1:0]       attr_i,
  input  logic                            out_free_i,
  output logic                            res_load_o,
  output tcw_pkg::result_t                res_o,
  output tcw_pkg::ram_req_t               ram_req_o,
  input  tcw_pkg::cell_t                  rd_data_i
);

  typedef enum logic [5:0] {
    StInit   = 6'b000001,
    StIdle   = 6'b000010,
    StRead   = 6'b000100,
    StScroll = 6'b001000,
    StFill   = 6'b010000,
    StDone   = 6'b100000
  } state_e;

  state_e            state_q, state_d;
  tcw_pkg::addr_t    idx_q, idx_d;
  tcw_pkg::row_t     row_q, row_d;
  tcw_pkg::col_t     col_q, col_d;
  tcw_pkg::cell_t    res_cell_q, res_cell_d;
  logic              rd_ok_q, rd_ok_d;
  tcw_pkg::addr_t    cursor_idx;
  logic              row_adv;
  logic              is_newline;

  assign cursor_idx = tcw_pkg::AddrW'(row_q) * tcw_pkg::AddrW'(tcw_pkg::Columns)
                    + tcw_pkg::AddrW'(col_q);
  assign is_newline = (char_code_i == tcw_pkg::NewlineCode);
  assign row_adv    = is_newline || (col_q == tcw_pkg::ColW'(tcw_pkg::Columns - 1));

  always_comb begin
    state_d    = state_q;
    idx_d      = idx_q;
    row_d      = row_q;
    col_d      = col_q;
    res_cell_d = res_cell_q;
    rd_ok_d    = rd_ok_q;
    res_load_o = 1'b0;
    ram_req_o  = '0;
    case (state_q)
      StInit: begin
        ram_req_o.we    = 1'b1;
        ram_req_o.waddr = idx_q;
        if (idx_q == tcw_pkg::AddrW'(tcw_pkg::CellCount - 1)) begin
          idx_d   = '0;
          state_d = StIdle;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      StIdle: begin
        if (in_valid_i) begin
          if (op_i) begin
            rd_ok_d         = int'(read_address_i) < tcw_pkg::CellCount;
            ram_req_o.re    = rd_ok_d;
            ram_req_o.raddr = tcw_pkg::AddrW'(read_address_i);
            state_d         = StRead;
          end else begin
            res_cell_d = '0;
            if (!is_newline) begin
              ram_req_o.we    = 1'b1;
              ram_req_o.waddr = cursor_idx;
              ram_req_o.wdata = {attr_i, char_code_i};
            end
            if (row_adv) begin
              col_d = '0;
              if (row_q == tcw_pkg::RowW'(tcw_pkg::Rows - 1)) begin
                idx_d   = '0;
                state_d = StScroll;
              end else begin
                row_d   = row_q + 1'b1;
                state_d = StDone;
              end
            end else begin
              col_d   = col_q + 1'b1;
              state_d = StDone;
            end
          end
        end
      end
      StRead: begin
        res_cell_d = rd_ok_q ? rd_data_i : '0;
        state_d    = StDone;
      end
      StScroll: begin
        // Read one row ahead while the cell read last cycle is written back
        // one place behind the current index.
        if (idx_q != tcw_pkg::AddrW'(tcw_pkg::CopyLen)) begin
          ram_req_o.re    = 1'b1;
          ram_req_o.raddr = idx_q + tcw_pkg::AddrW'(tcw_pkg::Columns);
        end
        if (idx_q != '0) begin
          ram_req_o.we    = 1'b1;
          ram_req_o.waddr = idx_q - 1'b1;
          ram_req_o.wdata = rd_data_i;
        end
        if (idx_q == tcw_pkg::AddrW'(tcw_pkg::CopyLen)) begin
          state_d = StFill;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      StFill: begin
        ram_req_o.we    = 1'b1;
        ram_req_o.waddr = idx_q;
        ram_req_o.wdata = {attr_i, tcw_pkg::SpaceCode};
        if (idx_q == tcw_pkg::AddrW'(tcw_pkg::CellCount - 1)) begin
          idx_d   = '0;
          state_d = StDone;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      StDone: begin
        if (out_free_i) begin
          res_load_o = 1'b1;
          state_d    = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StInit;
      idx_q      <= '0;
      row_q      <= '0;
      col_q      <= '0;
      rd_ok_q    <= 1'b0;
      res_cell_q <= '0;
    end else begin
      state_q    <= state_d;
      idx_q      <= idx_d;
      row_q      <= row_d;
      col_q      <= col_d;
      rd_ok_q    <= rd_ok_d;
      res_cell_q <= res_cell_d;
    end
  end

  assign in_stall_o = (state_q != StIdle);
  assign res_o.data = res_cell_q;
  assign res_o.row  = row_q;
  assign res_o.col  = col_q;

endmodule

// ===== rtl/text_console_writer_unit.sv =====
// Text console writer: an 80 by 25 character screen held in one synchronous
// memory, with a write cursor. A put request stores attribute and character at
// the cursor (a newline only moves the cursor) and returns the new cursor; a
// read request returns one cell and the cursor. A put that moves the cursor
// below the last row also scrolls the screen: every cell is copied one row up
// and the bottom row is blanked, one memory write per cycle. After reset the
// memory is cleared one cell per cycle, which holds the input stalled;
// attribute writes are taken at any time. The output register lets a new
// request enter while the previous result waits.
`timescale 1ns / 1ps
`include "text_console_writer_unit_defines.svh"
module text_console_writer_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          op_i,
  input  logic [tcw_pkg::CharW-1:0]     char_code_i,
  input  logic [tcw_pkg::ReadAddrW-1:0] read_address_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [tcw_pkg::CellW-1:0]     cell_value_o,
  output logic [tcw_pkg::RowW-1:0]      cursor_line_o,
  output logic [tcw_pkg::ColW-1:0]      cursor_column_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [tcw_pkg::CharW-1:0]     text_attribute_i
);

  logic [tcw_pkg::CharW-1:0] attr_q;
  logic                      out_valid_q;
  tcw_pkg::result_t          out_q;
  logic                      out_free;
  logic                      res_load;
  tcw_pkg::result_t          res;
  tcw_pkg::ram_req_t         ram_req;
  tcw_pkg::cell_t            rd_data;

  assign cfg_ready_o = 1'b1;
  assign out_free    = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attr_q      <= tcw_pkg::AttrReset;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        attr_q <= text_attribute_i;
      end
      if (res_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      out_q <= res;
    end
  end

  tcw_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .op_i           (op_i),
    .char_code_i    (char_code_i),
    .read_address_i (read_address_i),
    .attr_i         (attr_q),
    .out_free_i     (out_free),
    .res_load_o     (res_load),
    .res_o          (res),
    .ram_req_o      (ram_req),
    .rd_data_i      (rd_data)
  );

  tcw_screen_ram u_ram (
    .clk_i     (clk_i),
    .req_i     (ram_req),
    .rd_data_o (rd_data)
  );

  assign out_valid_o     = out_valid_q;
  assign cell_value_o    = out_q.data;
  assign cursor_line_o   = out_q.row;
  assign cursor_column_o = out_q.col;

  // An accepted request keeps the input side stalled until its result is out.
  `TCW_ASSERT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && !in_stall_o |=> in_stall_o)
  // A result is only loaded while the output register can take it.
  `TCW_ASSERT(a_load_when_free, clk_i, rst_ni, res_load |-> out_free)
  // Memory writes stay inside the screen.
  `TCW_ASSERT(a_write_in_range, clk_i, rst_ni, ram_req.we |-> int'(ram_req.waddr) < tcw_pkg::CellCount)
  // The cursor never reports a row below the screen.
  `TCW_ASSERT(a_row_in_range, clk_i, rst_ni, out_valid_o |-> int'(cursor_line_o) < tcw_pkg::Rows)

endmodule
